// File: design/nsc_pkg.sv
// Shared constants, codes and types for the NMEA sentence capture block.
package nsc_pkg;

    localparam int LINE_BYTES = 80;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int HEAD_BYTES = 6;
    localparam int ID_W       = 40;

    localparam logic [ID_W-1:0] ID_RESET = 40'h474E524D43;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // where read_data comes from once the request reaches the result side
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_BYTE = 2'd1;
    localparam logic [1:0] SRC_RAM  = 2'd2;

    typedef struct packed {
        logic [1:0] rd_src;
        logic [7:0] rd_byte;
        logic       done;
        logic       ready;
        logic [6:0] length;
    } nsc_res_t;

endpackage

// File: design/nsc_in_if.sv
// Request channel: opcode, received byte and read index.
interface nsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [6:0] read_index;

    modport source (output valid, output opcode, output rx_byte, output read_index,
                    input ready);
    modport sink (input valid, input opcode, input rx_byte, input read_index,
                  output ready);
endinterface

// File: design/nsc_out_if.sv
// Result channel: read data, completion, ready flag and sentence length.
interface nsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       sentence_done;
    logic       ready_res;
    logic [6:0] sentence_length;

    modport source (output valid, output read_data, output sentence_done,
                    output ready_res, output sentence_length, input ready);
    modport sink (input valid, input read_data, input sentence_done,
                  input ready_res, input sentence_length, output ready);
endinterface

// File: design/nsc_cfg_if.sv
// Configuration write channel carrying the sentence id.
interface nsc_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [nsc_pkg::ID_W-1:0] sentence_id;

    modport source (output valid, output sentence_id, input ready);
    modport sink (input valid, input sentence_id, output ready);
endinterface

// File: design/nsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/nsc_parser.sv
// Sentence parser: header match, capture control, line store writes and read routing.
module nsc_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  opcode,
    input  logic [7:0]                  rx_byte,
    input  logic [6:0]                  read_index,
    input  logic [nsc_pkg::ID_W-1:0]    sentence_id,
    output logic                        wr_en,
    output logic [nsc_pkg::ADDR_W-1:0]  wr_addr,
    output logic [7:0]                  wr_data,
    output logic                        rd_en,
    output logic [nsc_pkg::ADDR_W-1:0]  rd_addr,
    output nsc_pkg::nsc_res_t           res
);

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_HEADER  = 2'd1;
    localparam logic [1:0] MODE_CAPTURE = 2'd2;

    localparam int AW = nsc_pkg::ADDR_W;

    logic [1:0]    mode_reg, mode_next;
    logic [AW-1:0] fc_reg, fc_next;
    logic          ready_reg, ready_next;
    logic [6:0]    length_reg, length_next;
    logic [AW-1:0] term_pos_reg, term_pos_next;
    logic          term_valid_reg, term_valid_next;
    logic          term_pend_reg, term_pend_next;

    logic [7:0] trial_reg [0:3];
    logic [7:0] head_reg [0:4];

    logic [AW:0]  fc_inc;
    logic         is_rx;
    logic         id_match;
    logic         trial_we;
    logic         head_we;
    logic         cap_we;
    logic         done_now;
    logic [1:0]   trial_idx;
    logic         idx_in_range;

    assign is_rx     = accept && (opcode == nsc_pkg::OP_RX);
    assign fc_inc    = {1'b0, fc_reg} + (AW+1)'(1);
    assign trial_idx = 2'(fc_reg - AW'(1));
    assign id_match  = ({trial_reg[0], trial_reg[1], trial_reg[2], trial_reg[3], rx_byte}
                        == sentence_id);

    always_comb
    begin
        mode_next       = mode_reg;
        fc_next         = fc_reg;
        ready_next      = ready_reg;
        length_next     = length_reg;
        term_pos_next   = term_pos_reg;
        term_valid_next = term_valid_reg;
        term_pend_next  = 1'b0;
        trial_we        = 1'b0;
        head_we         = 1'b0;
        cap_we          = 1'b0;
        done_now        = 1'b0;

        if (is_rx)
        begin
            case (mode_reg)
                MODE_HEADER:
                begin
                    fc_next = AW'(fc_inc);
                    if (fc_reg == AW'(nsc_pkg::HEAD_BYTES - 1))
                    begin
                        if (id_match)
                        begin
                            head_we   = 1'b1;
                            mode_next = MODE_CAPTURE;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        trial_we = 1'b1;
                    end
                end
                MODE_CAPTURE:
                begin
                    cap_we = 1'b1;
                    if (fc_reg == term_pos_reg)
                    begin
                        term_valid_next = 1'b0;
                    end
                    // overflow is checked before the newline
                    if (fc_inc >= (AW+1)'(nsc_pkg::LINE_BYTES))
                    begin
                        fc_next   = '0;
                        mode_next = MODE_IDLE;
                    end
                    else if (rx_byte == nsc_pkg::CH_NEWLINE)
                    begin
                        term_pos_next   = AW'(fc_inc);
                        term_valid_next = 1'b1;
                        term_pend_next  = 1'b1;
                        length_next     = 7'(fc_inc);
                        ready_next      = 1'b1;
                        fc_next         = '0;
                        mode_next       = MODE_IDLE;
                        done_now        = 1'b1;
                    end
                    else
                    begin
                        fc_next = AW'(fc_inc);
                    end
                end
                default:
                begin
                    if (rx_byte == nsc_pkg::CH_DOLLAR)
                    begin
                        mode_next = MODE_HEADER;
                        fc_next   = AW'(1);
                    end
                end
            endcase
        end
        else if (accept && (opcode == nsc_pkg::OP_CLEAR))
        begin
            ready_next = 1'b0;
        end
    end

    // the terminator lands in the RAM the cycle after the newline, while the parser idles
    assign wr_en   = cap_we || term_pend_reg;
    assign wr_addr = term_pend_reg ? term_pos_reg : fc_reg;
    assign wr_data = term_pend_reg ? nsc_pkg::CH_NUL : rx_byte;

    // read routing: header bytes live in flops, the terminator is tracked by position
    assign idx_in_range = ({1'b0, read_index} < 8'(nsc_pkg::LINE_BYTES));
    assign rd_addr      = AW'(read_index);

    always_comb
    begin
        rd_en       = 1'b0;
        res.rd_src  = nsc_pkg::SRC_ZERO;
        res.rd_byte = nsc_pkg::CH_NUL;
        res.done    = done_now;
        res.ready   = ready_next;
        res.length  = length_next;
        if (accept && (opcode == nsc_pkg::OP_READ) && idx_in_range)
        begin
            if (read_index == 7'd0)
            begin
                res.rd_src  = nsc_pkg::SRC_BYTE;
                res.rd_byte = nsc_pkg::CH_DOLLAR;
            end
            else if (read_index < 7'(nsc_pkg::HEAD_BYTES))
            begin
                res.rd_src  = nsc_pkg::SRC_BYTE;
                res.rd_byte = head_reg[3'(read_index - 7'd1)];
            end
            else if (term_valid_reg && (AW'(read_index) == term_pos_reg))
            begin
                res.rd_src = nsc_pkg::SRC_ZERO;
            end
            else
            begin
                res.rd_src = nsc_pkg::SRC_RAM;
                rd_en      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            fc_reg         <= '0;
            ready_reg      <= 1'b0;
            length_reg     <= '0;
            term_pos_reg   <= '0;
            term_valid_reg <= 1'b0;
            term_pend_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            fc_reg         <= fc_next;
            ready_reg      <= ready_next;
            length_reg     <= length_next;
            term_pos_reg   <= term_pos_next;
            term_valid_reg <= term_valid_next;
            term_pend_reg  <= term_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (trial_we)
        begin
            trial_reg[trial_idx] <= rx_byte;
        end
        if (head_we)
        begin
            head_reg[0] <= trial_reg[0];
            head_reg[1] <= trial_reg[1];
            head_reg[2] <= trial_reg[2];
            head_reg[3] <= trial_reg[3];
            head_reg[4] <= rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_capture_past_header: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_CAPTURE) |-> (fc_reg >= AW'(nsc_pkg::HEAD_BYTES)))
        else $error("capture running inside the header region");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_now |=> (mode_reg == MODE_IDLE) && ready_reg && (fc_reg == '0))
        else $error("completed sentence did not settle the parser");

    a_term_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        term_valid_reg |-> (term_pos_reg > AW'(nsc_pkg::HEAD_BYTES)))
        else $error("terminator position inside the header");

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HEADER) |-> (fc_reg >= AW'(1))
            && (fc_reg < AW'(nsc_pkg::HEAD_BYTES)))
        else $error("header byte count out of range");

    a_term_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        term_pend_reg |-> !cap_we)
        else $error("terminator write collides with a capture write");
`endif

endmodule

// File: design/nsc_out_stage.sv
// Result side: holding stage for the RAM read and the result register.
module nsc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  nsc_pkg::nsc_res_t res,
    input  logic [7:0]        ram_q,
    output logic              in_ready,
    nsc_out_if.source         result
);

    logic              a_valid_reg, a_valid_next;
    nsc_pkg::nsc_res_t a_res_reg;
    logic              o_valid_reg, o_valid_next;
    logic [7:0]        o_data_reg;
    logic              o_done_reg;
    logic              o_ready_reg;
    logic [6:0]        o_length_reg;
    logic              a_move;
    logic [7:0]        rd_value;

    // the RAM data is held while the stage waits, since reads only fire on accept
    assign a_move   = a_valid_reg && (!o_valid_reg || result.ready);
    assign in_ready = !a_valid_reg || a_move;

    always_comb
    begin
        case (a_res_reg.rd_src)
            nsc_pkg::SRC_BYTE: rd_value = a_res_reg.rd_byte;
            nsc_pkg::SRC_RAM:  rd_value = ram_q;
            default:           rd_value = nsc_pkg::CH_NUL;
        endcase
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (a_move)
        begin
            o_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_res_reg <= res;
        end
        if (a_move)
        begin
            o_data_reg   <= rd_value;
            o_done_reg   <= a_res_reg.done;
            o_ready_reg  <= a_res_reg.ready;
            o_length_reg <= a_res_reg.length;
        end
    end

    assign result.valid           = o_valid_reg;
    assign result.read_data       = o_data_reg;
    assign result.sentence_done   = o_done_reg;
    assign result.ready_res       = o_ready_reg;
    assign result.sentence_length = o_length_reg;

endmodule

// File: design/nmea_sentence_capture.sv
// An accepted request is registered in the holding stage, then moved to the result register that drives result.valid.
// Throughput: one request per cycle while the output does not stall; two results can wait while the output stalls.
// Read data comes from the line store RAM's registered port in the middle stage.
// Reset: parser idle, ready flag and length cleared, id set to GNRMC;
// line store and header bytes are not cleared and stay undefined until written.
module nmea_sentence_capture (
    input  logic      clk,
    input  logic      rst_n,
    nsc_in_if.sink    item,
    nsc_cfg_if.sink   cfg,
    nsc_out_if.source result
);

    logic [nsc_pkg::ID_W-1:0]   id_reg;
    logic                       accept;
    logic                       in_ready;
    logic                       wr_en;
    logic [nsc_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;
    logic                       rd_en;
    logic [nsc_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 ram_q;
    nsc_pkg::nsc_res_t          res;

    assign cfg.ready  = 1'b1;
    assign item.ready = in_ready;
    assign accept     = item.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg <= nsc_pkg::ID_RESET;
        end
        else if (cfg.valid)
        begin
            id_reg <= cfg.sentence_id;
        end
    end

    nsc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (item.opcode),
        .rx_byte     (item.rx_byte),
        .read_index  (item.read_index),
        .sentence_id (id_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .res         (res)
    );

    nsc_ram #(
        .WIDTH (8),
        .DEPTH (nsc_pkg::LINE_BYTES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    nsc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .res      (res),
        .ram_q    (ram_q),
        .in_ready (in_ready),
        .result   (result)
    );

endmodule

// File: bench/nmea_sentence_capture_tb.sv
// Testbench for nmea_sentence_capture: random byte streams and reads, checked against a local model.
module nmea_sentence_capture_tb;

    localparam logic [1:0] OP_NONE          = 2'd3;
    localparam int         N_PHASES         = 6;
    localparam int         RANDOM_PER_PHASE = 225;
    localparam int         LONG_HOLD        = 60;

    typedef enum logic [1:0] {PARSE_IDLE, PARSE_HEADER, PARSE_CAPTURE} parse_mode_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } capture_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
        logic       flag;
        logic [6:0] len;
    } capture_res_t;

    typedef struct packed {
        logic [nsc_pkg::ID_W-1:0]               id;
        parse_mode_t                            mode;
        logic [6:0]                             fill;
        logic [0:4][7:0]                        hdr;
        logic [0:nsc_pkg::LINE_BYTES-1][7:0]    store;
        logic [0:nsc_pkg::LINE_BYTES-1]         filled;
        logic                                   flag;
        logic [6:0]                             len;
    } capture_state_t;

    logic clk;
    logic rst_n;

    nsc_in_if  req_ch ();
    nsc_out_if res_ch ();
    nsc_cfg_if cfg_ch ();

    nmea_sentence_capture dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    capture_req_t   pending_reqs[$];
    capture_res_t   expected_results[$];
    capture_state_t gen_state;
    capture_state_t chk_state;

    int fail_count;
    int requests_sent;
    int store_reads;
    int results_checked;
    int sentences_done;
    int id_writes;
    int queued_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_arm;
    int hold_cnt;
    bit hold_done;

    // One request applied to a copy of the block state; returns its result.
    function automatic capture_res_t capture_step(inout capture_state_t s,
                                                  input capture_req_t r);
        capture_res_t o;
        o = '0;
        case (r.opcode)
            nsc_pkg::OP_RX:
                case (s.mode)
                    PARSE_HEADER:
                    begin
                        if (s.fill >= 1 && s.fill <= 5)
                            s.hdr[s.fill - 1] = r.rx_byte;
                        s.fill = s.fill + 1;
                        if (s.fill >= nsc_pkg::HEAD_BYTES)
                        begin
                            if (s.hdr == s.id)
                            begin
                                s.store[0] = nsc_pkg::CH_DOLLAR;
                                s.filled[0] = 1'b1;
                                for (int i = 1; i < nsc_pkg::HEAD_BYTES; i++)
                                begin
                                    s.store[i] = s.hdr[i - 1];
                                    s.filled[i] = 1'b1;
                                end
                                s.mode = PARSE_CAPTURE;
                            end
                            else
                                s.mode = PARSE_IDLE;
                        end
                    end
                    PARSE_CAPTURE:
                    begin
                        // fill is always below LINE_BYTES while capturing
                        s.store[s.fill] = r.rx_byte;
                        s.filled[s.fill] = 1'b1;
                        s.fill = s.fill + 1;
                        if (s.fill >= nsc_pkg::LINE_BYTES)
                        begin
                            // full store: drop silently, even on a newline
                            s.fill = '0;
                            s.mode = PARSE_IDLE;
                        end
                        else if (r.rx_byte == nsc_pkg::CH_NEWLINE)
                        begin
                            s.store[s.fill] = nsc_pkg::CH_NUL;
                            s.filled[s.fill] = 1'b1;
                            s.len = s.fill;
                            s.flag = 1'b1;
                            s.fill = '0;
                            s.mode = PARSE_IDLE;
                            o.done = 1'b1;
                        end
                    end
                    default:
                        if (r.rx_byte == nsc_pkg::CH_DOLLAR)
                        begin
                            s.mode = PARSE_HEADER;
                            s.fill = 7'd1;
                        end
                endcase
            nsc_pkg::OP_READ:
                if (r.read_index < nsc_pkg::LINE_BYTES)
                    o.data = s.store[r.read_index];
            nsc_pkg::OP_CLEAR:
                s.flag = 1'b0;
            default: ;
        endcase
        o.flag = s.flag;
        o.len = s.len;
        return o;
    endfunction

    // Queue one request; a read of a never-written entry is moved past the store end.
    task automatic queue_req(input logic [1:0] opcode, input logic [7:0] rx_byte,
                             input logic [6:0] read_index);
        capture_req_t r;
        r.opcode = opcode;
        r.rx_byte = rx_byte;
        r.read_index = read_index;
        if (opcode == nsc_pkg::OP_READ && read_index < nsc_pkg::LINE_BYTES
            && !gen_state.filled[read_index])
            r.read_index = 7'(nsc_pkg::LINE_BYTES
                              + $urandom_range(127 - nsc_pkg::LINE_BYTES));
        pending_reqs.push_back(r);
        void'(capture_step(gen_state, r));
        queued_count++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        queue_req(nsc_pkg::OP_RX, b, 7'($urandom_range(127)));
    endtask

    task automatic queue_side_op();
        case ($urandom_range(2))
            0:       queue_req(nsc_pkg::OP_READ, 8'($urandom), 7'($urandom_range(127)));
            1:       queue_req(nsc_pkg::OP_CLEAR, 8'($urandom), 7'($urandom_range(127)));
            default: queue_req(OP_NONE, 8'($urandom), 7'($urandom_range(127)));
        endcase
    endtask

    // '$', five id header bytes; one corrupted if bad_pos >= 0, else body, then newline if set
    task automatic queue_sentence(input int body, input int bad_pos, input int dollar_pos,
                                  input bit newline, input bit mix_ops);
        logic [7:0] b;
        queue_byte(nsc_pkg::CH_DOLLAR);
        for (int i = 0; i < 5; i++)
        begin
            b = gen_state.id[8*(4-i) +: 8];
            if (i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            queue_byte(b);
        end
        if (bad_pos < 0)
        begin
            for (int i = 0; i < body; i++)
            begin
                if (mix_ops && $urandom_range(9) == 0)
                    queue_side_op();
                b = 8'($urandom_range(255));
                if (i == dollar_pos)
                    b = nsc_pkg::CH_DOLLAR;
                else if (b == nsc_pkg::CH_NEWLINE)
                    b = ~b;
                queue_byte(b);
            end
            if (newline)
                queue_byte(nsc_pkg::CH_NEWLINE);
        end
    endtask

    task automatic queue_random(input int target, input bit force_edges);
        int start;
        int ep;
        int k;
        int n;
        int room;
        start = queued_count;
        ep = 0;
        room = nsc_pkg::LINE_BYTES - nsc_pkg::HEAD_BYTES;
        while (queued_count - start < target)
        begin
            k = $urandom_range(99);
            if (force_edges && ep < 3)
                // newline in the last slot, overflow, longest sentence that fits
                case (ep)
                    0:       queue_sentence(room - 1, -1, -1, 1'b1, 1'b0);
                    1:       queue_sentence(room + $urandom_range(8), -1, -1, 1'b1, 1'b0);
                    default: queue_sentence(room - 2, -1, -1, 1'b1, 1'b0);
                endcase
            else if (k >= 98)
                queue_sentence(room - 1, -1, -1, 1'b1, 1'b1);
            else if (k >= 96)
                queue_sentence(room + $urandom_range(8), -1, -1, 1'b1, 1'b1);
            else if (k < 55)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(21, 72) : $urandom_range(20);
                queue_sentence(n, -1, ($urandom_range(5) == 0) ? $urandom_range(n) : -1,
                               1'b1, 1'b1);
                repeat ($urandom_range(3))
                    queue_req(nsc_pkg::OP_READ, 8'($urandom),
                              7'($urandom_range(gen_state.len)));
                if ($urandom_range(2) == 0)
                    queue_req(nsc_pkg::OP_CLEAR, 8'($urandom), 7'($urandom_range(127)));
            end
            else if (k < 67)
                queue_sentence(0, $urandom_range(4), -1, 1'b0, 1'b0);
            else if (k < 77)
                repeat ($urandom_range(1, 8))
                    queue_byte(8'($urandom));
            else if (k < 87)
                repeat ($urandom_range(1, 4))
                    queue_req(nsc_pkg::OP_READ, 8'($urandom), 7'($urandom_range(127)));
            else
                queue_side_op();
            ep++;
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_id(input logic [nsc_pkg::ID_W-1:0] v);
        cfg_ch.sentence_id <= v;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        gen_state.id = v;
        chk_state.id = v;
        id_writes++;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        capture_req_t cur;
        capture_req_t nxt;
        capture_res_t want;
        logic         advance;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.opcode <= nsc_pkg::OP_RX;
            req_ch.rx_byte <= '0;
            req_ch.read_index <= '0;
        end
        else
        begin
            advance = !req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                cur = {req_ch.opcode, req_ch.rx_byte, req_ch.read_index};
                want = capture_step(chk_state, cur);
                expected_results.push_back(want);
                requests_sent++;
                if (cur.opcode == nsc_pkg::OP_READ)
                    store_reads++;
                advance = 1'b1;
            end
            if (advance)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    req_ch.opcode <= nxt.opcode;
                    req_ch.rx_byte <= nxt.rx_byte;
                    req_ch.read_index <= nxt.read_index;
                    req_ch.valid <= 1'b1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        capture_res_t got;
        capture_res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.read_data, res_ch.sentence_done, res_ch.ready_res,
                       res_ch.sentence_length};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, got %0h", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.data, got.data);
                    check_field("sentence_done", 8'(want.done), 8'(got.done));
                    check_field("ready_res", 8'(want.flag), 8'(got.flag));
                    check_field("sentence_length", 8'(want.len), 8'(got.len));
                    results_checked++;
                    if (want.done)
                        sentences_done++;
                end
            end
            // long stall so the block backs up and drops its input ready
            if (long_hold_arm && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt == LONG_HOLD - 1)
                    hold_done <= 1'b1;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = nsc_pkg::OP_RX;
        req_ch.rx_byte = '0;
        req_ch.read_index = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.sentence_id = nsc_pkg::ID_RESET;
        gen_state = '0;
        gen_state.id = nsc_pkg::ID_RESET;
        chk_state = gen_state;
        send_idle_pct = 34;
        recv_idle_pct = 83;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                case (ph)
                    1:       write_id(40'h4750474741);
                    2:       write_id('0);
                    3:       write_id('1);
                    4:       write_id({8'($urandom_range(255)), 32'($urandom)});
                    default: write_id(nsc_pkg::ID_RESET);
                endcase
            end
            send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 83 : 0;
            recv_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 34 : 0;
            if (ph == 4)
                long_hold_arm = 1'b1;
            if (ph == 0)
            begin
                queue_req(nsc_pkg::OP_CLEAR, 8'h00, 7'd0);
                queue_req(OP_NONE, 8'hFF, 7'h7F);
                queue_req(nsc_pkg::OP_READ, 8'h00, 7'h7F);
                queue_sentence(0, -1, -1, 1'b1, 1'b0);
                queue_sentence(0, 4, -1, 1'b0, 1'b0);
                // '$' stored mid-sentence while the ready flag is still set
                queue_sentence(1, -1, 0, 1'b1, 1'b0);
                queue_req(nsc_pkg::OP_READ, 8'hFF, 7'd6);
                queue_req(nsc_pkg::OP_READ, 8'h00, 7'd8);
                queue_req(nsc_pkg::OP_CLEAR, 8'h00, 7'd0);
            end
            queue_random(RANDOM_PER_PHASE, ph == 1);
        end
        wait_idle();

        $display("Covered %0d requests (%0d store reads) under %0d written sentence ids,",
                 requests_sent, store_reads, id_writes);
        $display("with idle and stall patterns on both channels; %0d results compared, %0d %s",
                 results_checked, sentences_done, "sentences completed.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/nsc_pkg.sv
design/nsc_in_if.sv
design/nsc_out_if.sv
design/nsc_cfg_if.sv
design/nsc_ram.sv
design/nsc_parser.sv
design/nsc_out_stage.sv
design/nmea_sentence_capture.sv
bench/nmea_sentence_capture_tb.sv
